// File: hdl/rmbc_pkg.sv
package rmbc_pkg;

   localparam int NOW_WIDTH       = 32;
   localparam int CFG_WIDTH       = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [2:0]                 func_type;
   typedef logic [1:0]                 mode_type;
   typedef logic [1:0]                 flag_write_type;
   typedef logic [1:0]                 led_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CFG_WIDTH-1:0]       cfg_value_type;

   localparam func_type FUNC_LOOP     = 3'd0;
   localparam func_type FUNC_BOOT     = 3'd1;
   localparam func_type FUNC_DISABLE  = 3'd2;
   localparam func_type FUNC_CREDS    = 3'd3;
   localparam func_type FUNC_FORCE_AP = 3'd4;

   localparam mode_type MODE_OFF = 2'd0;
   localparam mode_type MODE_AP  = 2'd1;
   localparam mode_type MODE_STA = 2'd2;

   localparam flag_write_type FLAG_NONE  = 2'd0;
   localparam flag_write_type FLAG_CLEAR = 2'd1;
   localparam flag_write_type FLAG_SET   = 2'd2;

   localparam led_type LED_DARK  = 2'd0;
   localparam led_type LED_RED   = 2'd1;
   localparam led_type LED_BLUE  = 2'd2;
   localparam led_type LED_GREEN = 2'd3;

   localparam csr_index_type CSR_HOLD_TIME      = 2'd0;
   localparam csr_index_type CSR_DISABLE_DELAY  = 2'd1;
   localparam csr_index_type CSR_RETRY_INTERVAL = 2'd2;
   localparam csr_index_type CSR_BLINK_INTERVAL = 2'd3;

   localparam cfg_value_type HOLD_TIME_RESET      = 24'd5000;
   localparam cfg_value_type DISABLE_DELAY_RESET  = 24'd1000;
   localparam cfg_value_type RETRY_INTERVAL_RESET = 24'd10000;
   localparam cfg_value_type BLINK_INTERVAL_RESET = 24'd500;

   typedef struct packed {
      cfg_value_type hold_time;
      cfg_value_type disable_delay;
      cfg_value_type retry_interval;
      cfg_value_type blink_interval;
   } cfg_type;

   typedef struct packed {
      func_type             func;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 button_pressed;
      logic                 has_credentials;
      logic                 sta_connected;
      logic                 stored_disabled;
      logic                 ssid_present;
   } req_type;

   typedef struct packed {
      mode_type       mode;
      logic           start_ap;
      logic           start_sta;
      logic           radio_off;
      logic           retry_now;
      logic           announce;
      flag_write_type flag_write;
      logic           accepted;
      led_type        led_color;
      logic           led_write;
   } rsp_type;

   typedef struct packed {
      mode_type cur_mode;
      logic     btn_down;
      logic     hold_done;
      logic     off_pending;
      logic     announced;
      logic     blink_phase;
      led_type  last_color;
   } flags_type;

endpackage

// File: hdl/rmbc_if.sv
interface rmbc_req_if;
   logic                                  valid;
   logic                                  ready;
   rmbc_pkg::func_type                    func;
   logic [rmbc_pkg::NOW_WIDTH-1:0]        now_ms;
   logic                                  button_pressed;
   logic                                  has_credentials;
   logic                                  sta_connected;
   logic                                  stored_disabled;
   logic                                  ssid_present;

   modport source (
      output valid, func, now_ms, button_pressed, has_credentials, sta_connected,
             stored_disabled, ssid_present,
      input  ready
   );
   modport sink (
      input  valid, func, now_ms, button_pressed, has_credentials, sta_connected,
             stored_disabled, ssid_present,
      output ready
   );
endinterface

interface rmbc_rsp_if;
   logic                     valid;
   logic                     ready;
   rmbc_pkg::mode_type       mode;
   logic                     start_ap;
   logic                     start_sta;
   logic                     radio_off;
   logic                     retry_now;
   logic                     announce;
   rmbc_pkg::flag_write_type flag_write;
   logic                     accepted;
   rmbc_pkg::led_type        led_color;
   logic                     led_write;

   modport source (
      output valid, mode, start_ap, start_sta, radio_off, retry_now, announce,
             flag_write, accepted, led_color, led_write,
      input  ready
   );
   modport sink (
      input  valid, mode, start_ap, start_sta, radio_off, retry_now, announce,
             flag_write, accepted, led_color, led_write,
      output ready
   );
endinterface

// File: hdl/rmbc_csr.sv
module rmbc_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  rmbc_pkg::csr_index_type csr_index,
   input  rmbc_pkg::cfg_value_type csr_wdata,
   output rmbc_pkg::cfg_type       cfg
);

   rmbc_pkg::cfg_type cfg_ff;
   rmbc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rmbc_pkg::CSR_HOLD_TIME:      cfg_in.hold_time      = csr_wdata;
            rmbc_pkg::CSR_DISABLE_DELAY:  cfg_in.disable_delay  = csr_wdata;
            rmbc_pkg::CSR_RETRY_INTERVAL: cfg_in.retry_interval = csr_wdata;
            rmbc_pkg::CSR_BLINK_INTERVAL: cfg_in.blink_interval = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time      <= rmbc_pkg::HOLD_TIME_RESET;
         cfg_ff.disable_delay  <= rmbc_pkg::DISABLE_DELAY_RESET;
         cfg_ff.retry_interval <= rmbc_pkg::RETRY_INTERVAL_RESET;
         cfg_ff.blink_interval <= rmbc_pkg::BLINK_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/rmbc_eval.sv
module rmbc_eval #(
   parameter int TIME_WIDTH = 32
) (
   input  rmbc_pkg::cfg_type       cfg,
   input  rmbc_pkg::req_type       req,
   input  rmbc_pkg::flags_type     flags_cur,
   input  logic [TIME_WIDTH-1:0]   btn_since_cur,
   input  logic [TIME_WIDTH-1:0]   off_time_cur,
   input  logic [TIME_WIDTH-1:0]   retry_time_cur,
   input  logic [TIME_WIDTH-1:0]   toggle_time_cur,
   output rmbc_pkg::flags_type     flags_next,
   output logic [TIME_WIDTH-1:0]   btn_since_next,
   output logic [TIME_WIDTH-1:0]   off_time_next,
   output logic [TIME_WIDTH-1:0]   retry_time_next,
   output logic [TIME_WIDTH-1:0]   toggle_time_next,
   output rmbc_pkg::rsp_type       result
);

   // Compare width covers both the time difference and the 24-bit span.
   localparam int CMP_WIDTH = (TIME_WIDTH > rmbc_pkg::CFG_WIDTH) ?
                              TIME_WIDTH : rmbc_pkg::CFG_WIDTH;

   // Elapsed time is taken modulo the time width, so counter wrap is harmless.
   function automatic logic elapsed_ge(input logic [TIME_WIDTH-1:0] now_t,
                                       input logic [TIME_WIDTH-1:0] then_t,
                                       input rmbc_pkg::cfg_value_type span);
      logic [TIME_WIDTH-1:0] diff;
      diff = now_t - then_t;
      return CMP_WIDTH'(diff) >= CMP_WIDTH'(span);
   endfunction

   logic [TIME_WIDTH-1:0] now_t;

   assign now_t = TIME_WIDTH'(req.now_ms);

   always_comb begin
      flags_next       = flags_cur;
      btn_since_next   = btn_since_cur;
      off_time_next    = off_time_cur;
      retry_time_next  = retry_time_cur;
      toggle_time_next = toggle_time_cur;

      result            = '0;
      result.accepted   = 1'b1;
      result.flag_write = rmbc_pkg::FLAG_NONE;
      result.led_color  = flags_cur.last_color;

      unique case (req.func)
         rmbc_pkg::FUNC_BOOT: begin
            if (req.stored_disabled) begin
               flags_next.cur_mode = rmbc_pkg::MODE_OFF;
               result.radio_off    = 1'b1;
            end else if (req.has_credentials) begin
               flags_next.cur_mode  = rmbc_pkg::MODE_STA;
               result.start_sta     = 1'b1;
               flags_next.announced = 1'b0;
               retry_time_next      = now_t;
            end else begin
               flags_next.cur_mode  = rmbc_pkg::MODE_AP;
               result.start_ap      = 1'b1;
               result.announce      = 1'b1;
               flags_next.announced = 1'b1;
            end
         end
         rmbc_pkg::FUNC_DISABLE: begin
            flags_next.off_pending = 1'b1;
            off_time_next          = now_t;
         end
         rmbc_pkg::FUNC_CREDS: begin
            if (req.ssid_present) begin
               flags_next.cur_mode  = rmbc_pkg::MODE_STA;
               result.start_sta     = 1'b1;
               flags_next.announced = 1'b0;
               retry_time_next      = now_t;
            end else begin
               result.accepted = 1'b0;
            end
         end
         rmbc_pkg::FUNC_FORCE_AP: begin
            result.flag_write    = rmbc_pkg::FLAG_CLEAR;
            flags_next.cur_mode  = rmbc_pkg::MODE_AP;
            result.start_ap      = 1'b1;
            result.announce      = 1'b1;
            flags_next.announced = 1'b1;
         end
         rmbc_pkg::FUNC_LOOP: begin
            // Button: a long hold forces access point, a tap wakes from off.
            if (req.button_pressed) begin
               if (!flags_cur.btn_down) begin
                  flags_next.btn_down  = 1'b1;
                  btn_since_next       = now_t;
                  flags_next.hold_done = 1'b0;
               end else if (!flags_cur.hold_done &&
                            elapsed_ge(now_t, btn_since_cur, cfg.hold_time)) begin
                  flags_next.hold_done = 1'b1;
                  result.flag_write    = rmbc_pkg::FLAG_CLEAR;
                  flags_next.cur_mode  = rmbc_pkg::MODE_AP;
                  result.start_ap      = 1'b1;
                  result.announce      = 1'b1;
                  flags_next.announced = 1'b1;
               end
            end else begin
               if (flags_cur.btn_down && !flags_cur.hold_done &&
                   flags_cur.cur_mode == rmbc_pkg::MODE_OFF) begin
                  result.flag_write = rmbc_pkg::FLAG_CLEAR;
                  if (req.has_credentials) begin
                     flags_next.cur_mode  = rmbc_pkg::MODE_STA;
                     result.start_sta     = 1'b1;
                     flags_next.announced = 1'b0;
                     retry_time_next      = now_t;
                  end else begin
                     flags_next.cur_mode  = rmbc_pkg::MODE_AP;
                     result.start_ap      = 1'b1;
                     result.announce      = 1'b1;
                     flags_next.announced = 1'b1;
                  end
               end
               flags_next.btn_down  = 1'b0;
               flags_next.hold_done = 1'b0;
            end

            // Deferred disable; its flag write overrides the button's.
            if (flags_cur.off_pending &&
                elapsed_ge(now_t, off_time_cur, cfg.disable_delay)) begin
               flags_next.off_pending = 1'b0;
               flags_next.cur_mode    = rmbc_pkg::MODE_OFF;
               result.radio_off       = 1'b1;
               flags_next.announced   = 1'b0;
               result.flag_write      = rmbc_pkg::FLAG_SET;
            end

            // Retry uses the retry time as possibly just restamped above.
            if (flags_next.cur_mode == rmbc_pkg::MODE_STA && !req.sta_connected &&
                elapsed_ge(now_t, retry_time_next, cfg.retry_interval)) begin
               retry_time_next  = now_t;
               result.retry_now = 1'b1;
            end

            if (flags_next.cur_mode == rmbc_pkg::MODE_STA) begin
               if (req.sta_connected) begin
                  if (!flags_next.announced) begin
                     result.announce      = 1'b1;
                     flags_next.announced = 1'b1;
                  end
               end else begin
                  flags_next.announced = 1'b0;
               end
            end

            if (elapsed_ge(now_t, toggle_time_cur, cfg.blink_interval)) begin
               toggle_time_next       = now_t;
               flags_next.blink_phase = !flags_cur.blink_phase;
            end

            if (flags_next.cur_mode == rmbc_pkg::MODE_OFF || !flags_next.blink_phase) begin
               result.led_color = rmbc_pkg::LED_DARK;
            end else if (!req.has_credentials) begin
               result.led_color = rmbc_pkg::LED_RED;
            end else if (!req.sta_connected) begin
               result.led_color = rmbc_pkg::LED_BLUE;
            end else begin
               result.led_color = rmbc_pkg::LED_GREEN;
            end
            result.led_write      = (result.led_color != flags_cur.last_color);
            flags_next.last_color = result.led_color;
         end
         default: begin
            result.accepted = 1'b1;
         end
      endcase

      result.mode = flags_next.cur_mode;
   end

endmodule

// File: hdl/radio_mode_button_controller_core.sv
// Channel  | Direction | Contents
// req_ch   | in        | one event word: func, now_ms, button and link status bits
// rsp_ch   | out       | one result word per event: mode, action flags, status light
// csr_*    | in        | write-only register port: hold, disable, retry, blink times
//
// A word accepted on req_ch is held in the input register, evaluated into the result register
// and then offered on rsp_ch; one word per cycle while rsp_ch.ready stays high.
// State commits as a word enters the result register, so the next word sees its effects.
// A stalled result holds its register; once the input register also fills, req_ch.ready
// drops until rsp_ch.ready returns. Reset is synchronous and active high; it restores the
// register defaults and clears all mode, button, disable, retry, announce and blink state.
module radio_mode_button_controller_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   rmbc_req_if.sink                req_ch,
   rmbc_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  rmbc_pkg::csr_index_type csr_index,
   input  rmbc_pkg::cfg_value_type csr_wdata
);

   rmbc_pkg::cfg_type cfg;

   rmbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register stage.
   logic              in_valid_ff;
   rmbc_pkg::req_type in_word_ff;
   rmbc_pkg::req_type in_word_in;

   // Result register stage.
   logic              rsp_valid_ff;
   rmbc_pkg::rsp_type rsp_word_ff;
   rmbc_pkg::rsp_type result;

   // Controller state.
   rmbc_pkg::flags_type   flags_ff;
   rmbc_pkg::flags_type   flags_in;
   logic [TIME_WIDTH-1:0] btn_since_ff;
   logic [TIME_WIDTH-1:0] btn_since_in;
   logic [TIME_WIDTH-1:0] off_time_ff;
   logic [TIME_WIDTH-1:0] off_time_in;
   logic [TIME_WIDTH-1:0] retry_time_ff;
   logic [TIME_WIDTH-1:0] retry_time_in;
   logic [TIME_WIDTH-1:0] toggle_time_ff;
   logic [TIME_WIDTH-1:0] toggle_time_in;

   logic advance;
   logic req_take;

   // The evaluated word moves on when the result register is empty or being drained.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   assign in_word_in.func            = req_ch.func;
   assign in_word_in.now_ms          = req_ch.now_ms;
   assign in_word_in.button_pressed  = req_ch.button_pressed;
   assign in_word_in.has_credentials = req_ch.has_credentials;
   assign in_word_in.sta_connected   = req_ch.sta_connected;
   assign in_word_in.stored_disabled = req_ch.stored_disabled;
   assign in_word_in.ssid_present    = req_ch.ssid_present;

   rmbc_eval #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_eval (
      .cfg              (cfg),
      .req              (in_word_ff),
      .flags_cur        (flags_ff),
      .btn_since_cur    (btn_since_ff),
      .off_time_cur     (off_time_ff),
      .retry_time_cur   (retry_time_ff),
      .toggle_time_cur  (toggle_time_ff),
      .flags_next       (flags_in),
      .btn_since_next   (btn_since_in),
      .off_time_next    (off_time_in),
      .retry_time_next  (retry_time_in),
      .toggle_time_next (toggle_time_in),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= in_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   // State commits only when its word lands in the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff       <= '0;
         btn_since_ff   <= '0;
         off_time_ff    <= '0;
         retry_time_ff  <= '0;
         toggle_time_ff <= '0;
      end else if (advance) begin
         flags_ff       <= flags_in;
         btn_since_ff   <= btn_since_in;
         off_time_ff    <= off_time_in;
         retry_time_ff  <= retry_time_in;
         toggle_time_ff <= toggle_time_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mode       = rsp_word_ff.mode;
   assign rsp_ch.start_ap   = rsp_word_ff.start_ap;
   assign rsp_ch.start_sta  = rsp_word_ff.start_sta;
   assign rsp_ch.radio_off  = rsp_word_ff.radio_off;
   assign rsp_ch.retry_now  = rsp_word_ff.retry_now;
   assign rsp_ch.announce   = rsp_word_ff.announce;
   assign rsp_ch.flag_write = rsp_word_ff.flag_write;
   assign rsp_ch.accepted   = rsp_word_ff.accepted;
   assign rsp_ch.led_color  = rsp_word_ff.led_color;
   assign rsp_ch.led_write  = rsp_word_ff.led_write;

`ifndef NO_ASSERTIONS
   // The remembered light color always matches the color last reported.
   a_led_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.led_color == flags_ff.last_color)
      else $error("last_color differs from the reported light color");

   // A radio shutdown always leaves the controller in the off mode.
   a_off_means_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.radio_off) |-> rsp_word_ff.mode == rmbc_pkg::MODE_OFF)
      else $error("radio_off reported with a mode other than off");

   // Reconnect attempts happen only in station mode.
   a_retry_in_sta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.retry_now) |-> rsp_word_ff.mode == rmbc_pkg::MODE_STA)
      else $error("retry_now reported outside station mode");

   // A completed hold can only exist while the button is tracked as down.
   a_hold_needs_press: assert property (@(posedge clock) disable iff (reset)
      flags_ff.hold_done |-> flags_ff.btn_down)
      else $error("hold_done set without btn_down");

   // Committed state and reported mode agree for the word just evaluated.
   a_mode_commit: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_word_ff.mode == flags_ff.cur_mode)
      else $error("reported mode differs from committed mode");
`endif

endmodule

// File: sim/radio_mode_button_controller_core_tb.sv
module radio_mode_button_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmbc_pkg::*;

   // Event codes that the block does not define. They must be answered with no action.
   localparam func_type FUNC_SPARE_A = FUNC_FORCE_AP + 3'd1;
   localparam func_type FUNC_SPARE_B = FUNC_FORCE_AP + 3'd2;
   localparam func_type FUNC_SPARE_C = FUNC_FORCE_AP + 3'd3;

   // The run is declared hung after this many cycles in which no word moves on
   // either channel. The longest legal gap is a receiver stall streak plus a
   // register load, which is well below this.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 180;
   localparam int PHASE_COUNT    = 6;

   // One row of the directed table: the event word and, where the answer is
   // obvious, the status word typed in by hand.
   typedef struct packed {
      req_type word;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   localparam rsp_type NO_STATUS = '0;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   cfg_value_type csr_wdata;

   rmbc_req_if req_ch ();
   rmbc_rsp_if rsp_ch ();

   radio_mode_button_controller_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the controller: register copy and the state that the status
   // words are computed from.
   cfg_type       csr_shadow = '{hold_time: HOLD_TIME_RESET,
                                 disable_delay: DISABLE_DELAY_RESET,
                                 retry_interval: RETRY_INTERVAL_RESET,
                                 blink_interval: BLINK_INTERVAL_RESET};
   mode_type      pred_mode     = MODE_OFF;
   logic          press_seen    = 1'b0;
   logic [31:0]   press_ms      = '0;
   logic          hold_fired    = 1'b0;
   logic          disable_armed = 1'b0;
   logic [31:0]   disable_ms    = '0;
   logic [31:0]   retry_ms      = '0;
   logic          name_sent     = 1'b0;
   logic          blink_on      = 1'b0;
   logic [31:0]   blink_ms      = '0;
   led_type       shown_color   = LED_DARK;

   // Status words still owed by the block, oldest first.
   rsp_type status_backlog[$];
   stim_row_type directed_table[$];

   int send_idle_pct = 34;
   int recv_idle_pct = 82;
   int idle_cycles   = 0;
   int failures      = 0;
   int words_sent    = 0;
   int status_checked = 0;
   int holds_seen    = 0;
   int taps_seen     = 0;
   int disables_fired = 0;
   int retries_seen  = 0;
   int announces_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Wrap-safe elapsed time test: the difference is taken modulo 2^32.
   function automatic logic span_reached(logic [31:0] t, logic [31:0] since,
                                         cfg_value_type span);
      logic [31:0] gap;
      gap = t - since;
      return gap >= {8'd0, span};
   endfunction

   function automatic void enter_ap(inout rsp_type r);
      pred_mode   = MODE_AP;
      r.start_ap  = 1'b1;
      r.announce  = 1'b1;
      name_sent   = 1'b1;
   endfunction

   function automatic void enter_station(inout rsp_type r, input logic [31:0] t);
      pred_mode   = MODE_STA;
      r.start_sta = 1'b1;
      name_sent   = 1'b0;
      retry_ms    = t;
   endfunction

   // Computes the status word for one event word and advances the shadow state.
   function automatic rsp_type controller_next(req_type w);
      rsp_type     r;
      led_type     color;
      logic [31:0] t;
      r          = '0;
      r.accepted = 1'b1;
      r.led_color = shown_color;
      t = w.now_ms;
      case (w.func)
         FUNC_BOOT: begin
            if (w.stored_disabled) begin
               // A stored disable keeps the radio down and is not rewritten.
               pred_mode   = MODE_OFF;
               r.radio_off = 1'b1;
            end else if (w.has_credentials) begin
               enter_station(r, t);
            end else begin
               enter_ap(r);
            end
         end
         FUNC_DISABLE: begin
            // A repeated request restarts the delay.
            disable_armed = 1'b1;
            disable_ms    = t;
         end
         FUNC_CREDS: begin
            if (w.ssid_present) enter_station(r, t);
            else r.accepted = 1'b0;
         end
         FUNC_FORCE_AP: begin
            r.flag_write = FLAG_CLEAR;
            enter_ap(r);
         end
         FUNC_LOOP: begin
            if (w.button_pressed) begin
               if (!press_seen) begin
                  press_seen = 1'b1;
                  press_ms   = t;
                  hold_fired = 1'b0;
               end else if (!hold_fired && span_reached(t, press_ms, csr_shadow.hold_time)) begin
                  hold_fired   = 1'b1;
                  r.flag_write = FLAG_CLEAR;
                  enter_ap(r);
                  holds_seen++;
               end
            end else begin
               if (press_seen && !hold_fired && pred_mode == MODE_OFF) begin
                  r.flag_write = FLAG_CLEAR;
                  if (w.has_credentials) enter_station(r, t);
                  else enter_ap(r);
                  taps_seen++;
               end
               press_seen = 1'b0;
               hold_fired = 1'b0;
            end

            // A firing disable comes after the button, so its flag write wins.
            if (disable_armed && span_reached(t, disable_ms, csr_shadow.disable_delay)) begin
               disable_armed = 1'b0;
               pred_mode     = MODE_OFF;
               r.radio_off   = 1'b1;
               name_sent     = 1'b0;
               r.flag_write  = FLAG_SET;
               disables_fired++;
            end

            if (pred_mode == MODE_STA && !w.sta_connected &&
                span_reached(t, retry_ms, csr_shadow.retry_interval)) begin
               retry_ms    = t;
               r.retry_now = 1'b1;
               retries_seen++;
            end

            if (pred_mode == MODE_STA) begin
               if (w.sta_connected) begin
                  if (!name_sent) begin
                     r.announce = 1'b1;
                     name_sent  = 1'b1;
                     announces_seen++;
                  end
               end else begin
                  name_sent = 1'b0;
               end
            end

            if (span_reached(t, blink_ms, csr_shadow.blink_interval)) begin
               blink_ms = t;
               blink_on = ~blink_on;
            end
            if (pred_mode == MODE_OFF || !blink_on) color = LED_DARK;
            else if (!w.has_credentials) color = LED_RED;
            else if (!w.sta_connected) color = LED_BLUE;
            else color = LED_GREEN;
            r.led_color = color;
            if (color != shown_color) begin
               r.led_write = 1'b1;
               shown_color = color;
            end
         end
         default: begin
         end
      endcase
      r.mode = pred_mode;
      return r;
   endfunction

   function automatic rsp_type status_word(mode_type m, logic ap, logic sta, logic off,
                                           logic retry, logic ann, flag_write_type fw,
                                           logic acc, led_type led, logic lw);
      rsp_type r;
      r = {m, ap, sta, off, retry, ann, fw, acc, led, lw};
      return r;
   endfunction

   // Columns of bits: button_pressed, has_credentials, sta_connected,
   // stored_disabled, ssid_present.
   function automatic void add_row(func_type f, logic [31:0] t, logic [4:0] bits,
                                   logic typed, rsp_type want);
      stim_row_type row;
      row.word.func   = f;
      row.word.now_ms = t;
      {row.word.button_pressed, row.word.has_credentials, row.word.sta_connected,
       row.word.stored_disabled, row.word.ssid_present} = bits;
      row.typed = typed;
      row.want  = want;
      directed_table.push_back(row);
   endfunction

   // Offers one event word, with a random gap first, and records the status word
   // it is owed once the block takes it. Called and returns at a rising edge.
   task automatic send_word(input req_type w, input logic typed, input rsp_type want);
      rsp_type predicted;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.func            <= w.func;
      req_ch.now_ms          <= w.now_ms;
      req_ch.button_pressed  <= w.button_pressed;
      req_ch.has_credentials <= w.has_credentials;
      req_ch.sta_connected   <= w.sta_connected;
      req_ch.stored_disabled <= w.stored_disabled;
      req_ch.ssid_present    <= w.ssid_present;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = controller_next(w);
      status_backlog.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   // Stops offering words and waits until every owed status word has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (status_backlog.size() != 0);
   endtask

   task automatic csr_write(input csr_index_type idx, input cfg_value_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_HOLD_TIME:      csr_shadow.hold_time      = value;
         CSR_DISABLE_DELAY:  csr_shadow.disable_delay  = value;
         CSR_RETRY_INTERVAL: csr_shadow.retry_interval = value;
         CSR_BLINK_INTERVAL: csr_shadow.blink_interval = value;
         default: begin
         end
      endcase
   endtask

   // Registers are only loaded with the block empty. Every event owes exactly one
   // status word, so an empty backlog means nothing is left in the pipeline; the
   // extra wait is only a margin over the two register stages.
   task automatic load_settings(input cfg_type s);
      drain_results();
      repeat (2) @(posedge clock);
      csr_write(CSR_HOLD_TIME, s.hold_time);
      csr_write(CSR_DISABLE_DELAY, s.disable_delay);
      csr_write(CSR_RETRY_INTERVAL, s.retry_interval);
      csr_write(CSR_BLINK_INTERVAL, s.blink_interval);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // The receiver stalls at random according to the current idling regime.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Timeout: no word moved for %0d cycles, %0d status words owed.",
               WATCHDOG_LIMIT, status_backlog.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Every status word taken from the block is matched against the oldest one owed.
   always @(posedge clock) begin : status_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = {rsp_ch.mode, rsp_ch.start_ap, rsp_ch.start_sta, rsp_ch.radio_off,
                rsp_ch.retry_now, rsp_ch.announce, rsp_ch.flag_write, rsp_ch.accepted,
                rsp_ch.led_color, rsp_ch.led_write};
         if (status_backlog.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected status word at %0t: %p", $realtime, got);
         end else begin
            want = status_backlog.pop_front();
            status_checked++;
            if (got !== want) begin
               failures++;
               if (failures <= 10) begin
                  $display("Status word %0d mismatch at %0t:", status_checked, $realtime);
                  $display("  expected mode=%0d ap=%0d sta=%0d off=%0d retry=%0d ann=%0d",
                           want.mode, want.start_ap, want.start_sta, want.radio_off,
                           want.retry_now, want.announce);
                  $display("           flag=%0d acc=%0d led=%0d led_write=%0d",
                           want.flag_write, want.accepted, want.led_color, want.led_write);
                  $display("  actual   mode=%0d ap=%0d sta=%0d off=%0d retry=%0d ann=%0d",
                           got.mode, got.start_ap, got.start_sta, got.radio_off,
                           got.retry_now, got.announce);
                  $display("           flag=%0d acc=%0d led=%0d led_write=%0d",
                           got.flag_write, got.accepted, got.led_color, got.led_write);
               end
            end
         end
      end
   end

   initial begin : stimulus
      cfg_type     plan;
      req_type     w;
      int unsigned longest;
      int unsigned step_max;
      int          pick;
      int          pause_at;
      logic        btn;
      logic        creds;
      logic        link;
      logic [31:0] now_track;

      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_HOLD_TIME;
      csr_wdata              <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.func            <= FUNC_LOOP;
      req_ch.now_ms          <= '0;
      req_ch.button_pressed  <= 1'b0;
      req_ch.has_credentials <= 1'b0;
      req_ch.sta_connected   <= 1'b0;
      req_ch.stored_disabled <= 1'b0;
      req_ch.ssid_present    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words run with the register defaults from reset. Bits are
      // pressed, credentials, connected, stored disable, network name.
      add_row(FUNC_LOOP, 32'd0, 5'b00000, 1'b1,
              status_word(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FLAG_NONE, 1'b1,
                          LED_DARK, 1'b0));
      add_row(FUNC_BOOT, 32'd0, 5'b00010, 1'b1,
              status_word(MODE_OFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FLAG_NONE, 1'b1,
                          LED_DARK, 1'b0));
      add_row(FUNC_CREDS, 32'd0, 5'b00000, 1'b1,
              status_word(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FLAG_NONE, 1'b0,
                          LED_DARK, 1'b0));
      // A press that starts at time zero, held to one below and then exactly the hold time.
      add_row(FUNC_LOOP, 32'd0, 5'b10000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd4999, 5'b10000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd5000, 5'b10000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd5100, 5'b00000, 1'b0, NO_STATUS);
      // A second disable request restarts the delay; it fires one delay after it.
      add_row(FUNC_DISABLE, 32'd6000, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_DISABLE, 32'd6500, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd7000, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd7500, 5'b10000, 1'b0, NO_STATUS);
      // A tap from off and a firing disable in one pass: the set flag wins.
      add_row(FUNC_DISABLE, 32'd7600, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'd8600, 5'b01000, 1'b0, NO_STATUS);
      // Station retry measured across the wrap of the millisecond counter.
      add_row(FUNC_CREDS, 32'hFFFF_FF00, 5'b00001, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'hFFFF_FFFF, 5'b01000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'h0000_2800, 5'b01000, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'h0000_3000, 5'b01100, 1'b0, NO_STATUS);
      add_row(FUNC_FORCE_AP, 32'h0000_3100, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_BOOT, 32'h0000_3200, 5'b01000, 1'b0, NO_STATUS);
      add_row(FUNC_BOOT, 32'h0000_3300, 5'b00000, 1'b0, NO_STATUS);
      // Undefined event codes, with every status bit both ways.
      add_row(FUNC_SPARE_A, 32'h0000_3400, 5'b11111, 1'b0, NO_STATUS);
      add_row(FUNC_SPARE_B, 32'h0000_3500, 5'b00000, 1'b0, NO_STATUS);
      add_row(FUNC_SPARE_C, 32'hFFFF_FFFF, 5'b11111, 1'b0, NO_STATUS);
      add_row(FUNC_LOOP, 32'hFFFF_FFFF, 5'b11111, 1'b0, NO_STATUS);

      for (int i = 0; i < directed_table.size(); i++)
         send_word(directed_table[i].word, directed_table[i].typed, directed_table[i].want);

      // Random phases. The button, credentials and link bits are sticky and flip
      // now and then, and time mostly moves forward in steps scaled to the
      // register values, so holds, taps, deferred disables, retries and blinks
      // all get reached. A few words carry a fully random time.
      btn       = 1'b0;
      creds     = 1'b0;
      link      = 1'b0;
      now_track = 32'h0001_0000;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: plan = '0;
            1: begin
               plan      = '1;
               now_track = 32'hFF00_0000;
            end
            2: begin
               plan.hold_time      = cfg_value_type'($urandom_range(1, 300));
               plan.disable_delay  = cfg_value_type'($urandom_range(1, 300));
               plan.retry_interval = cfg_value_type'($urandom_range(1, 300));
               plan.blink_interval = cfg_value_type'($urandom_range(1, 300));
            end
            3: begin
               plan.hold_time      = cfg_value_type'($urandom_range(0, 50));
               plan.disable_delay  = '1;
               plan.retry_interval = cfg_value_type'(1);
               plan.blink_interval = '0;
            end
            4: begin
               plan.hold_time      = HOLD_TIME_RESET;
               plan.disable_delay  = DISABLE_DELAY_RESET;
               plan.retry_interval = RETRY_INTERVAL_RESET;
               plan.blink_interval = BLINK_INTERVAL_RESET;
            end
            default: begin
               plan.hold_time      = cfg_value_type'($urandom_range(0, 20000));
               plan.disable_delay  = cfg_value_type'($urandom_range(0, 20000));
               plan.retry_interval = cfg_value_type'($urandom_range(0, 20000));
               plan.blink_interval = cfg_value_type'($urandom_range(0, 20000));
            end
         endcase
         load_settings(plan);

         // Idling regimes: sender light and receiver heavy, then swapped, then none.
         if (phase < 2) begin
            send_idle_pct = 34;
            recv_idle_pct = 82;
         end else if (phase < 4) begin
            send_idle_pct = 82;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         longest = 32'(plan.hold_time);
         if (32'(plan.disable_delay) > longest) longest = 32'(plan.disable_delay);
         if (32'(plan.retry_interval) > longest) longest = 32'(plan.retry_interval);
         if (32'(plan.blink_interval) > longest) longest = 32'(plan.blink_interval);
         step_max = longest / 4 + 16;
         pause_at = $urandom_range(20, PHASE_WORDS - 20);

         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Once per phase the sender holds off until the block has answered everything.
            if (n == pause_at) drain_results();

            if ($urandom_range(0, 99) < 7) btn = ~btn;
            if ($urandom_range(0, 99) < 5) creds = ~creds;
            if ($urandom_range(0, 99) < 8) link = ~link;

            pick = $urandom_range(0, 99);
            if (pick < 3) now_track = $urandom;
            else if (pick < 40) now_track = now_track + $urandom_range(0, 16);
            else now_track = now_track + $urandom_range(0, step_max);

            pick = $urandom_range(0, 99);
            if (pick < 66) w.func = FUNC_LOOP;
            else if (pick < 74) w.func = FUNC_DISABLE;
            else if (pick < 80) w.func = FUNC_CREDS;
            else if (pick < 85) w.func = FUNC_FORCE_AP;
            else if (pick < 92) w.func = FUNC_BOOT;
            else if (pick < 95) w.func = FUNC_SPARE_A + func_type'($urandom_range(0, 2));
            else w.func = FUNC_LOOP;

            w.now_ms          = now_track;
            w.button_pressed  = btn;
            w.has_credentials = creds;
            w.sta_connected   = link;
            w.stored_disabled = ($urandom_range(0, 99) < 30);
            w.ssid_present    = ($urandom_range(0, 99) < 85);
            send_word(w, 1'b0, NO_STATUS);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (status_backlog.size() != 0) failures += status_backlog.size();

      $display("Covered %0d event words over %0d register settings; %0d status words checked.",
               words_sent, PHASE_COUNT + 1, status_checked);
      $display("Saw %0d holds, %0d taps, %0d deferred disables, %0d retries, %0d announcements.",
               holds_seen, taps_seen, disables_fired, retries_seen, announces_seen);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d status word failures.", failures);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
